// ===== rtl/smb_pkg.sv =====
// types and constants shared by the softmax backward vector block
`default_nettype none

package smb_pkg;

    // fixed field widths
    localparam int unsigned DATA_W = 32;
    localparam int unsigned POS_W  = 6;

    // accumulate_gain after reset: 1.0 in Q16.16
    localparam logic signed [DATA_W-1:0] GAIN_RESET = 32'sh0001_0000;

    // saturation limits of the dot product accumulator
    localparam logic signed [63:0] ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] ACC_MIN = 64'sh8000_0000_0000_0000;

    // cap on the magnitude of y*(dy - s)
    localparam logic [63:0] MAG_CAP = 64'h0004_0000_0000_0000;

    // limits of a 32-bit result
    localparam logic signed [53:0] RES_MAX = 54'sh00_0000_7FFF_FFFF;
    localparam logic signed [53:0] RES_MIN = -54'sh00_0000_8000_0000;

    // one request: one element of the axis vector
    typedef struct packed {
        logic signed [DATA_W-1:0] out_value;
        logic signed [DATA_W-1:0] out_gradient;
        logic signed [DATA_W-1:0] prior_gradient;
        logic                     vector_end;
    } request_t;

    // one result: one input gradient element
    typedef struct packed {
        logic signed [DATA_W-1:0] in_gradient;
        logic [POS_W-1:0]         element_position;
        logic                     run_end;
        logic                     overflowed;
    } result_t;

    // one stored element
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] grad;
        logic signed [DATA_W-1:0] prior;
    } entry_t;

    // magnitude of a signed 32-bit value, unsigned so that -2^31 fits
    function automatic logic [DATA_W-1:0] mag32(input logic signed [DATA_W-1:0] v);
        logic [DATA_W-1:0] m;
        m = v[DATA_W-1] ? (~v + 32'd1) : v;
        return m;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/softmax_backward_vector.sv =====
// softmax backward pass over one axis vector, built around one shared multiplier
//
// channel   signals                           direction  notes
// request   start, busy, request              in         taken when start && !busy
// result    result_valid, result              out        one-cycle strobe, no backpressure
// config    cfg_valid, cfg_ready, cfg_data    in         accumulate_gain, ready always high
//
// a stored element passes through the accept, multiply and accumulate steps
// the vector_end element then forms s, and each stored element in turn passes through
// the read, subtract, two partial products, gain product and saturate steps
// the one 32x32 multiplier is shared over every product
// rst_n clears the sequencer, the accumulator and the fill count and sets the gain to 1.0
// the stores hold no reset value; only entries written in the current vector are read
`default_nettype none

module softmax_backward_vector
    import smb_pkg::*;
#(
    parameter int unsigned MAX_AXIS_LEN = 64
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire request_t          request,
    output logic                   result_valid,
    output result_t                result,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [DATA_W-1:0] cfg_data
);

    localparam int unsigned IDX_W = (MAX_AXIS_LEN > 1) ? $clog2(MAX_AXIS_LEN) : 1;
    localparam int unsigned CNT_W = $clog2(MAX_AXIS_LEN + 1);

    // sequencer codes
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_LMUL  = 4'd1;
    localparam logic [3:0] S_LACC  = 4'd2;
    localparam logic [3:0] S_SCALE = 4'd3;
    localparam logic [3:0] S_READ  = 4'd4;
    localparam logic [3:0] S_DIFF  = 4'd5;
    localparam logic [3:0] S_HI    = 4'd6;
    localparam logic [3:0] S_LO    = 4'd7;
    localparam logic [3:0] S_BETA  = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    logic [3:0]               state_reg, state_next;
    logic [CNT_W-1:0]         fill_reg, fill_next;
    logic signed [63:0]       acc_reg, acc_next;
    logic signed [DATA_W-1:0] gain_reg, gain_next;
    logic [IDX_W-1:0]         k_reg, k_next;
    logic                     last_reg, last_next;
    logic [DATA_W-1:0]        mag_a_reg, mag_a_next;
    logic [DATA_W-1:0]        mag_b_reg, mag_b_next;
    logic                     neg_reg, neg_next;
    logic                     gneg_reg, gneg_next;
    logic [63:0]              prod_reg, prod_next;
    logic signed [48:0]       s_reg, s_next;
    logic [47:0]              md_reg, md_next;
    logic [63:0]              mag_reg, mag_next;
    logic [50:0]              tmag_reg, tmag_next;
    result_t                  result_reg, result_next;
    logic                     result_valid_reg, result_valid_next;

    // element store
    entry_t                   entry_mem [MAX_AXIS_LEN];
    entry_t                   rd_reg;
    logic                     wr_en;
    entry_t                   wr_entry;

    // shared multiplier
    logic [DATA_W-1:0]        mul_a, mul_b;
    logic [63:0]              mul_p;

    logic                     accept;
    logic                     has_room;

    assign busy         = (state_reg != S_IDLE);
    assign accept       = start && !busy;
    assign has_room     = (fill_reg < CNT_W'(MAX_AXIS_LEN));
    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    assign wr_en    = accept && has_room;
    assign wr_entry = '{value: request.out_value, grad: request.out_gradient,
                        prior: request.prior_gradient};

    // store write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_mem[fill_reg[IDX_W-1:0]] <= wr_entry;
        end
        rd_reg <= entry_mem[k_reg];
    end

    // multiplier operand select
    always_comb
    begin
        case (state_reg)
            S_LMUL:
            begin
                mul_a = mag_a_reg;
                mul_b = mag_b_reg;
            end
            S_HI:
            begin
                mul_a = mag_a_reg;
                mul_b = md_reg[47:16];
            end
            S_LO:
            begin
                mul_a = mag_a_reg;
                mul_b = {16'd0, md_reg[15:0]};
            end
            S_BETA:
            begin
                mul_a = mag32(gain_reg);
                mul_b = mag_b_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // sequencer and datapath
    always_comb
    begin
        logic signed [64:0] term65;
        logic signed [64:0] sum65;
        logic [63:0]        acc_mag;
        logic signed [48:0] s_abs;
        logic signed [48:0] diff_s;
        logic [48:0]        diff_mag;
        logic [63:0]        sum64;
        logic signed [53:0] t_s;
        logic signed [53:0] b_s;
        logic signed [53:0] x_s;

        state_next        = state_reg;
        fill_next         = fill_reg;
        acc_next          = acc_reg;
        gain_next         = gain_reg;
        k_next            = k_reg;
        last_next         = last_reg;
        mag_a_next        = mag_a_reg;
        mag_b_next        = mag_b_reg;
        neg_next          = neg_reg;
        gneg_next         = gneg_reg;
        prod_next         = mul_p;
        s_next            = s_reg;
        md_next           = md_reg;
        mag_next          = mag_reg;
        tmag_next         = tmag_reg;
        result_next       = result_reg;
        result_valid_next = 1'b0;

        term65   = '0;
        sum65    = '0;
        acc_mag  = '0;
        s_abs    = '0;
        diff_s   = '0;
        diff_mag = '0;
        sum64    = '0;
        t_s      = '0;
        b_s      = '0;
        x_s      = '0;

        // gain register write
        if (cfg_valid && cfg_ready)
        begin
            gain_next = signed'(cfg_data);
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    last_next  = request.vector_end;
                    mag_a_next = mag32(request.out_value);
                    mag_b_next = mag32(request.out_gradient);
                    neg_next   = request.out_value[DATA_W-1] ^ request.out_gradient[DATA_W-1];
                    if (has_room)
                    begin
                        state_next = S_LMUL;
                    end
                    else if (request.vector_end)
                    begin
                        state_next = S_SCALE;
                    end
                end
            end

            S_LMUL:
            begin
                state_next = S_LACC;
            end

            // saturating accumulate of y*dy
            S_LACC:
            begin
                term65 = signed'({1'b0, prod_reg});
                if (neg_reg)
                begin
                    term65 = -term65;
                end
                sum65 = 65'(acc_reg) + term65;
                if (sum65 > 65'(ACC_MAX))
                begin
                    acc_next = ACC_MAX;
                end
                else if (sum65 < 65'(ACC_MIN))
                begin
                    acc_next = ACC_MIN;
                end
                else
                begin
                    acc_next = sum65[63:0];
                end
                fill_next  = fill_reg + CNT_W'(1);
                state_next = last_reg ? S_SCALE : S_IDLE;
            end

            // s = acc >> 16, truncated toward zero
            S_SCALE:
            begin
                acc_mag = acc_reg[63] ? (~acc_reg + 64'd1) : acc_reg;
                s_abs   = signed'({1'b0, acc_mag[63:16]});
                s_next  = acc_reg[63] ? -s_abs : s_abs;
                k_next  = '0;
                state_next = S_READ;
            end

            S_READ:
            begin
                state_next = S_DIFF;
            end

            // dy - s and operand magnitudes
            S_DIFF:
            begin
                diff_s     = 49'(rd_reg.grad) - s_reg;
                diff_mag   = diff_s[48] ? (~diff_s + 49'd1) : diff_s;
                md_next    = diff_mag[47:0];
                mag_a_next = mag32(rd_reg.value);
                mag_b_next = mag32(rd_reg.prior);
                neg_next   = rd_reg.value[DATA_W-1] ^ diff_s[48];
                gneg_next  = rd_reg.prior[DATA_W-1] ^ gain_reg[DATA_W-1];
                state_next = S_HI;
            end

            S_HI:
            begin
                state_next = S_LO;
            end

            S_LO:
            begin
                mag_next   = prod_reg;
                state_next = S_BETA;
            end

            // combine partial products and cap
            S_BETA:
            begin
                sum64 = mag_reg + {16'd0, prod_reg[63:16]};
                if (sum64 > MAG_CAP)
                begin
                    tmag_next = MAG_CAP[50:0];
                end
                else
                begin
                    tmag_next = sum64[50:0];
                end
                state_next = S_OUT;
            end

            // add the gain term and saturate
            S_OUT:
            begin
                t_s = signed'({3'd0, tmag_reg});
                if (neg_reg)
                begin
                    t_s = -t_s;
                end
                b_s = signed'({6'd0, prod_reg[63:16]});
                if (gneg_reg)
                begin
                    b_s = -b_s;
                end
                x_s = t_s + b_s;
                if (x_s > RES_MAX)
                begin
                    result_next.in_gradient = RES_MAX[31:0];
                    result_next.overflowed  = 1'b1;
                end
                else if (x_s < RES_MIN)
                begin
                    result_next.in_gradient = RES_MIN[31:0];
                    result_next.overflowed  = 1'b1;
                end
                else
                begin
                    result_next.in_gradient = x_s[31:0];
                    result_next.overflowed  = 1'b0;
                end
                result_next.element_position = POS_W'(k_reg);
                result_next.run_end = ((CNT_W'(k_reg) + CNT_W'(1)) == fill_reg);
                result_valid_next   = 1'b1;
                if ((CNT_W'(k_reg) + CNT_W'(1)) == fill_reg)
                begin
                    acc_next   = '0;
                    fill_next  = '0;
                    k_next     = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    k_next     = k_reg + IDX_W'(1);
                    state_next = S_READ;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            fill_reg         <= '0;
            acc_reg          <= '0;
            gain_reg         <= GAIN_RESET;
            k_reg            <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            fill_reg         <= fill_next;
            acc_reg          <= acc_next;
            gain_reg         <= gain_next;
            k_reg            <= k_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        last_reg   <= last_next;
        mag_a_reg  <= mag_a_next;
        mag_b_reg  <= mag_b_next;
        neg_reg    <= neg_next;
        gneg_reg   <= gneg_next;
        prod_reg   <= prod_next;
        s_reg      <= s_next;
        md_reg     <= md_next;
        mag_reg    <= mag_next;
        tmag_reg   <= tmag_next;
        result_reg <= result_next;
    end

`ifndef SYNTHESIS
    // a result only follows the saturate step
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(state_reg == S_OUT))
        else $error("result strobe without a saturate step");

    // the fill count never passes the store depth
    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(MAX_AXIS_LEN))
        else $error("fill count beyond store depth");

    // the last result leaves the vector state cleared and the block idle
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.run_end |-> fill_reg == '0 && acc_reg == '0 && !busy)
        else $error("vector state not cleared after last result");

    // a stored request goes straight to the multiply step
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && has_room |=> state_reg == S_LMUL)
        else $error("stored request did not reach the multiply step");

    // emit pass only runs over stored elements
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIFF |-> CNT_W'(k_reg) < fill_reg)
        else $error("read beyond the filled part of the store");
`endif

endmodule

`default_nettype wire

// ===== test/softmax_backward_vector_checker.sv =====
// checker for the softmax backward vector block: predicts input gradients and compares results
`default_nettype none

module softmax_backward_vector_checker
    import smb_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic              busy,
    input  wire request_t          request,
    input  wire logic              result_valid,
    input  wire result_t           result,
    input  wire logic              cfg_valid,
    input  wire logic              cfg_ready,
    input  wire logic [DATA_W-1:0] cfg_data,
    output int                     mismatches,
    output int                     grads_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     AXIS_DEPTH   = 64;
    localparam int     REPORT_LIMIT = 10;
    localparam longint SUM_MAX      = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint SUM_MIN      = 64'sh8000_0000_0000_0000;
    localparam longint GRAD_MAX     = 64'sh0000_0000_7FFF_FFFF;
    localparam longint GRAD_MIN     = -64'sh0000_0000_8000_0000;
    localparam longint unsigned PRODUCT_CAP = 64'd1 << 50;

    // shadow of the block's vector stores and running dot product
    logic signed [DATA_W-1:0] value_mem [AXIS_DEPTH];
    logic signed [DATA_W-1:0] grad_mem  [AXIS_DEPTH];
    logic signed [DATA_W-1:0] prior_mem [AXIS_DEPTH];
    longint                   dot_sum;
    int                       stored;
    logic signed [DATA_W-1:0] gain;

    result_t pending_grads [$];
    result_t want;

    // magnitude as unsigned, so the most negative value still fits
    function automatic longint unsigned abs64(input longint v);
        longint unsigned m;
        m = (v < 0) ? -v : v;
        return m;
    endfunction

    // drop 16 fraction bits, rounding toward zero
    function automatic longint shr16_toward_zero(input longint v);
        longint unsigned m;
        m = abs64(v) >> 16;
        return (v < 0) ? -longint'(m) : longint'(m);
    endfunction

    // store one element, and on the last one queue the input gradient of every stored element
    task automatic predict_input_grads(input request_t e);
        longint          prod;
        longint          sum;
        longint          s;
        longint          ey;
        longint          diff;
        longint          t;
        longint unsigned my;
        longint unsigned md;
        longint unsigned mag;
        logic            ovf;
        result_t         r;
        int              k;

        // elements past the end of the store are neither kept nor summed
        if (stored < AXIS_DEPTH)
        begin
            grad_mem[stored]  = e.out_gradient;
            prior_mem[stored] = e.prior_gradient;
            value_mem[stored] = e.out_value;
            prod = longint'($signed(e.out_value)) * longint'($signed(e.out_gradient));
            sum  = dot_sum + prod;
            if (dot_sum[63] == prod[63] && sum[63] != prod[63])
                sum = prod[63] ? SUM_MIN : SUM_MAX;
            dot_sum = sum;
            stored++;
        end
        if (e.vector_end)
        begin
            s = shr16_toward_zero(dot_sum);
            for (k = 0; k < stored; k++)
            begin
                ey   = longint'(value_mem[k]);
                diff = longint'(grad_mem[k]) - s;
                my   = abs64(ey);
                md   = abs64(diff);
                mag  = my * (md >> 16) + ((my * (md & 64'hFFFF)) >> 16);
                if (mag > PRODUCT_CAP)
                    mag = PRODUCT_CAP;
                t = ((ey < 0) != (diff < 0)) ? -longint'(mag) : longint'(mag);
                // a zero gain leaves the prior gradient out
                if (gain != 0)
                    t += shr16_toward_zero(longint'(gain) * longint'(prior_mem[k]));
                ovf = 1'b0;
                if (t > GRAD_MAX)
                begin
                    t   = GRAD_MAX;
                    ovf = 1'b1;
                end
                if (t < GRAD_MIN)
                begin
                    t   = GRAD_MIN;
                    ovf = 1'b1;
                end
                r.in_gradient      = t[DATA_W-1:0];
                r.element_position = k[POS_W-1:0];
                r.run_end          = (k == stored - 1);
                r.overflowed       = ovf;
                pending_grads.push_back(r);
            end
            dot_sum = 0;
            stored  = 0;
        end
    endtask

    // watch all three channels on every edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_sum    = 0;
            stored     = 0;
            gain       = GAIN_RESET;
            mismatches = 0;
            pending_grads.delete();
            grads_pending <= 0;
        end
        else
        begin
            // results are compared against the oldest prediction
            if (result_valid)
            begin
                if (pending_grads.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: unexpected result %h pos %0d end %b ovf %b",
                                 $realtime, result.in_gradient, result.element_position,
                                 result.run_end, result.overflowed);
                end
                else
                begin
                    want = pending_grads.pop_front();
                    if (result.in_gradient !== want.in_gradient
                        || result.element_position !== want.element_position
                        || result.run_end !== want.run_end
                        || result.overflowed !== want.overflowed)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display("%0t: expected %h/%0d/%b/%b, got %h/%0d/%b/%b",
                                     $realtime, want.in_gradient, want.element_position,
                                     want.run_end, want.overflowed, result.in_gradient,
                                     result.element_position, result.run_end,
                                     result.overflowed);
                    end
                end
            end
            // gain register write
            if (cfg_valid && cfg_ready)
                gain = cfg_data;
            // accepted request
            if (start && !busy)
                predict_input_grads(request);
            grads_pending <= pending_grads.size();
        end
    end

endmodule

`default_nettype wire

// ===== test/tb_softmax_backward_vector.sv =====
// testbench top for the softmax backward vector block: stimulus, gain writes and verdict
`default_nettype none

module tb_softmax_backward_vector
    import smb_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          RANDOM_ITEMS  = 130;
    localparam int          SETTLE_CYCLES = 24;
    localparam int          DRAIN_LIMIT   = 20000;
    localparam logic [31:0] Q_MAX         = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN         = 32'h8000_0000;
    localparam logic [31:0] Q_ONE         = 32'h0001_0000;
    localparam logic [31:0] Q_NEG_ONE_LSB = 32'hFFFF_FFFF;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              start;
    logic              busy;
    request_t          request;
    logic              result_valid;
    result_t           result;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [DATA_W-1:0] cfg_data;
    int                mismatches;
    int                grads_pending;
    bit                steady;

    always #1 clk = ~clk;

    softmax_backward_vector dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    softmax_backward_vector_checker grad_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .request       (request),
        .result_valid  (result_valid),
        .result        (result),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .grads_pending (grads_pending)
    );

    // Q16.16 value: half the time small, else any pattern or an extreme
    function automatic logic [31:0] pick_fixed();
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: v = $urandom_range(0, 32'h0003_0000) - 32'h0001_8000;
            5, 6, 7:       v = $urandom;
            8:             v = Q_MAX;
            default:       v = Q_MIN;
        endcase
        return v;
    endfunction

    // one element request; start stays high on return so back-to-back requests need no gap
    task automatic send_element(input logic [31:0] y, input logic [31:0] dy,
                                input logic [31:0] g, input logic last);
        int       gap;
        request_t r;
        gap = 0;
        if (!steady)
            gap = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(3, 40);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        r.out_value      = y;
        r.out_gradient   = dy;
        r.prior_gradient = g;
        r.vector_end     = last;
        start   <= 1'b1;
        request <= r;
        do @(posedge clk); while (busy);
    endtask

    // hold off until every predicted result is out and the block has gone quiet
    task automatic drain_and_settle();
        start <= 1'b0;
        @(posedge clk);
        while (grads_pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // gain write, only with the block idle
    task automatic write_gain(input logic [31:0] g);
        drain_and_settle();
        cfg_valid <= 1'b1;
        cfg_data  <= g;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // stimulus
    initial
    begin
        int          items;
        int          vectors;
        int          len;
        int          waited;
        logic [31:0] g;

        rst_n     = 1'b0;
        start     = 1'b0;
        request   = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        steady    = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single-element vectors at the reset gain
        send_element(Q_ONE, 32'h0000_8000, Q_ONE, 1'b1);
        send_element(32'h0, 32'h0, 32'h0, 1'b1);
        send_element(Q_NEG_ONE_LSB, Q_NEG_ONE_LSB, Q_NEG_ONE_LSB, 1'b1);
        // field extremes
        send_element(Q_MAX, Q_MIN, Q_MAX, 1'b0);
        send_element(Q_MIN, Q_MAX, Q_MIN, 1'b0);
        send_element(Q_MIN, Q_MIN, Q_MIN, 1'b1);
        // dot product saturates high
        send_element(Q_MIN, Q_MIN, Q_ONE, 1'b0);
        send_element(Q_MIN, Q_MIN, Q_ONE, 1'b0);
        send_element(Q_MIN, Q_MIN, Q_ONE, 1'b1);
        // dot product saturates low
        send_element(Q_MIN, Q_MAX, 32'h0, 1'b0);
        send_element(Q_MIN, Q_MAX, 32'h0, 1'b0);
        send_element(Q_MIN, Q_MAX, 32'h0, 1'b1);

        // zero gain drops the prior gradient
        write_gain(32'h0);
        send_element(32'h0000_8000, 32'h0002_0000, Q_MAX, 1'b0);
        send_element(32'h0000_8000, Q_ONE, Q_MIN, 1'b1);

        // largest gain: prior term saturates both ways
        write_gain(Q_MAX);
        send_element(Q_MAX, 32'h0, Q_MAX, 1'b0);
        send_element(32'h0, 32'h0, Q_MIN, 1'b1);

        // most negative gain against the capped product
        write_gain(Q_MIN);
        send_element(Q_MAX, Q_MIN, Q_MAX, 1'b1);

        write_gain(Q_ONE);

        // random vectors, gain changed every few vectors
        items   = 0;
        vectors = 0;
        while (items < RANDOM_ITEMS)
        begin
            if (vectors == 4)
                len = $urandom_range(66, 70);
            else if ($urandom_range(0, 5) == 0)
                len = $urandom_range(9, 20);
            else
                len = $urandom_range(1, 8);
            steady = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < len; i++)
                send_element(pick_fixed(), pick_fixed(), pick_fixed(), i == len - 1);
            steady = 1'b0;
            items += len;
            vectors++;
            // now and then the sender holds off until the pipeline is empty
            if ($urandom_range(0, 7) == 0)
                drain_and_settle();
            if (vectors % 6 == 0)
            begin
                case ($urandom_range(0, 5))
                    0:       g = 32'h0;
                    1:       g = Q_ONE;
                    2:       g = Q_MAX;
                    3:       g = Q_MIN;
                    4:       g = $urandom;
                    default: g = $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
                endcase
                write_gain(g);
            end
        end

        // wait out the last results, then a few quiet cycles
        start <= 1'b0;
        @(posedge clk);
        waited = 0;
        while (grads_pending != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (grads_pending != 0)
        begin
            $display("** softmax_backward_vector: FAILED **");
        end
        else
        begin
            repeat (SETTLE_CYCLES) @(posedge clk);
            if (mismatches == 0)
                $display("** softmax_backward_vector: PASSED **");
            else
                $display("** softmax_backward_vector: FAILED **");
        end
        $finish;
    end

    // watchdog
    initial
    begin
        #500us;
        $display("** softmax_backward_vector: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/smb_pkg.sv
rtl/softmax_backward_vector.sv
test/softmax_backward_vector_checker.sv
test/tb_softmax_backward_vector.sv
